/* rtl/lpfd_pkg.sv */
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types for the length-prefixed frame deframer: the parse phase
// encoding and the result item that travels from the parser to the output
// register.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  // Widths fixed by the frame format.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FieldW = 16;

  // Parse phase, one-hot. Each header byte has a phase of its own.
  typedef enum logic [6:0] {
    PH_ID_HI   = 7'b000_0001,
    PH_ID_LO   = 7'b000_0010,
    PH_CTRL_HI = 7'b000_0100,
    PH_CTRL_LO = 7'b000_1000,
    PH_LEN_HI  = 7'b001_0000,
    PH_LEN_LO  = 7'b010_0000,
    PH_DATA    = 7'b100_0000
  } phase_e;

  // One result item.
  typedef struct packed {
    logic [FieldW-1:0] conn_id;
    logic [FieldW-1:0] ctrl_field;
    logic [ByteW-1:0]  payload_byte;
    logic              has_byte;
    logic              frame_last;
  } res_t;

endpackage

/* rtl/length_prefixed_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_top
// Splits a byte stream into frames of a 16-bit connection id, a 16-bit
// control field, a 16-bit length and that many payload bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one raw stream byte per item (in_valid_i,
// in_ready_o, in_byte_i). All header fields are big-endian. Header bytes
// give no result. Every payload byte gives one result item carrying the
// frame's id and control field, with frame_last_o set on the final byte.
// A frame of length zero gives a single item with has_byte_o low, a zero
// payload byte and frame_last_o high.
// A byte accepted into the input register is parsed from there, and its result
// is loaded into the result register: the parser works within the cycle
// between the input register and the result register.
// The block accepts one byte every cycle while the receiver does not stall;
// the parser's state is registered, and the input and result registers
// overlap with its update.
// When the receiver stalls, the held result stays put; header bytes keep
// flowing until a byte that needs a result meets the full result register,
// and only then does in_ready_o drop.
// Reset clears the parse phase to the start of a frame and empties both
// registers; a partly received frame is dropped.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lpfd_pkg::ByteW-1:0]  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lpfd_pkg::FieldW-1:0] conn_id_o,
  output logic [lpfd_pkg::FieldW-1:0] ctrl_field_o,
  output logic [lpfd_pkg::ByteW-1:0]  payload_byte_o,
  output logic                        has_byte_o,
  output logic                        frame_last_o
);

  logic                       in_valid;
  logic [lpfd_pkg::ByteW-1:0] in_byte;
  logic                       take;
  logic                       res_valid;
  logic                       out_free;
  lpfd_pkg::res_t             res;
  lpfd_pkg::res_t             out_res;

  lpfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .take_i     (take),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  lpfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid),
    .byte_i      (in_byte),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign conn_id_o      = out_res.conn_id;
  assign ctrl_field_o   = out_res.ctrl_field;
  assign payload_byte_o = out_res.payload_byte;
  assign has_byte_o     = out_res.has_byte;
  assign frame_last_o   = out_res.frame_last;

endmodule

/* rtl/lpfd_in_reg.sv */
// ----------------------------------------------------------------------------
// lpfd_in_reg
// Input register. Captures one byte item and holds it until the parser
// takes it; a new item may be captured in the same cycle as the old one
// is taken.
// ----------------------------------------------------------------------------
module lpfd_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [lpfd_pkg::ByteW-1:0] in_byte_i,
  input  logic                       take_i,
  output logic                       valid_o,
  output logic [lpfd_pkg::ByteW-1:0] byte_o
);

  logic                       valid_q, valid_d;
  logic [lpfd_pkg::ByteW-1:0] byte_q;
  logic                       load;

  // The register is free when empty or emptied this cycle.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

/* rtl/lpfd_parser.sv */
// ----------------------------------------------------------------------------
// lpfd_parser
// Frame parser. Walks the six header bytes, holds the connection id,
// control field and remaining payload count, and forms one result for each
// payload byte or for an empty frame.
// ----------------------------------------------------------------------------
module lpfd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [lpfd_pkg::ByteW-1:0] byte_i,
  input  logic                       out_free_i,
  output logic                       take_o,
  output logic                       res_valid_o,
  output lpfd_pkg::res_t             res_o
);

  lpfd_pkg::phase_e              phase_q, phase_d, phase_eff;
  logic [lpfd_pkg::FieldW-1:0]   id_q, id_d;
  logic [lpfd_pkg::FieldW-1:0]   ctrl_q, ctrl_d;
  logic [lpfd_pkg::ByteW-1:0]    len_hi_q, len_hi_d;
  logic [lpfd_pkg::FieldW-1:0]   remain_q, remain_d;
  logic [lpfd_pkg::FieldW-1:0]   len_full;
  logic                          res_needed;
  logic                          last_byte;

  assign len_full  = {len_hi_q, byte_i};
  assign last_byte = (remain_q == lpfd_pkg::FieldW'(1));

  // A payload phase with nothing left behaves as the start of a new frame.
  always_comb begin
    phase_eff = phase_q;
    if (phase_q == lpfd_pkg::PH_DATA && remain_q == '0) begin
      phase_eff = lpfd_pkg::PH_ID_HI;
    end
  end

  // Only the payload bytes and the empty-frame marker produce a result.
  assign res_needed = (phase_eff == lpfd_pkg::PH_DATA) ||
                      (phase_eff == lpfd_pkg::PH_LEN_LO && len_full == '0);

  // Take the item unless its result would meet a full output register.
  assign take_o      = valid_i && (!res_needed || out_free_i);
  assign res_valid_o = take_o && res_needed;

  // Result fields.
  always_comb begin
    res_o.conn_id      = id_q;
    res_o.ctrl_field   = ctrl_q;
    res_o.payload_byte = '0;
    res_o.has_byte     = 1'b0;
    res_o.frame_last   = 1'b1;
    if (phase_eff == lpfd_pkg::PH_DATA) begin
      res_o.payload_byte = byte_i;
      res_o.has_byte     = 1'b1;
      res_o.frame_last   = last_byte;
    end
  end

  // Next-state logic for the phase and the header registers.
  always_comb begin
    phase_d  = phase_q;
    id_d     = id_q;
    ctrl_d   = ctrl_q;
    len_hi_d = len_hi_q;
    remain_d = remain_q;
    if (take_o) begin
      unique case (phase_eff)
        lpfd_pkg::PH_ID_LO: begin
          id_d    = {id_q[lpfd_pkg::FieldW-1:lpfd_pkg::ByteW], byte_i};
          phase_d = lpfd_pkg::PH_CTRL_HI;
        end
        lpfd_pkg::PH_CTRL_HI: begin
          ctrl_d  = {byte_i, {lpfd_pkg::ByteW{1'b0}}};
          phase_d = lpfd_pkg::PH_CTRL_LO;
        end
        lpfd_pkg::PH_CTRL_LO: begin
          ctrl_d  = {ctrl_q[lpfd_pkg::FieldW-1:lpfd_pkg::ByteW], byte_i};
          phase_d = lpfd_pkg::PH_LEN_HI;
        end
        lpfd_pkg::PH_LEN_HI: begin
          len_hi_d = byte_i;
          phase_d  = lpfd_pkg::PH_LEN_LO;
        end
        lpfd_pkg::PH_LEN_LO: begin
          remain_d = len_full;
          phase_d  = (len_full == '0) ? lpfd_pkg::PH_ID_HI : lpfd_pkg::PH_DATA;
        end
        lpfd_pkg::PH_DATA: begin
          remain_d = remain_q - lpfd_pkg::FieldW'(1);
          phase_d  = last_byte ? lpfd_pkg::PH_ID_HI : lpfd_pkg::PH_DATA;
        end
        default: begin
          // Expect the connection id high byte.
          id_d    = {byte_i, {lpfd_pkg::ByteW{1'b0}}};
          phase_d = lpfd_pkg::PH_ID_LO;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lpfd_pkg::PH_ID_HI;
      id_q     <= '0;
      ctrl_q   <= '0;
      len_hi_q <= '0;
      remain_q <= '0;
    end else begin
      phase_q  <= phase_d;
      id_q     <= id_d;
      ctrl_q   <= ctrl_d;
      len_hi_q <= len_hi_d;
      remain_q <= remain_d;
    end
  end

endmodule

/* rtl/lpfd_out_reg.sv */
// ----------------------------------------------------------------------------
// lpfd_out_reg
// Result register. Holds one result item until the receiver takes it and
// reloads in the same cycle the held item leaves.
// ----------------------------------------------------------------------------
module lpfd_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  lpfd_pkg::res_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lpfd_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  lpfd_pkg::res_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/lpfd_checker.sv */
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level checks for the frame deframer, bound to its top level.
// ----------------------------------------------------------------------------
module lpfd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [lpfd_pkg::FieldW-1:0] conn_id_o,
  input logic [lpfd_pkg::FieldW-1:0] ctrl_field_o,
  input logic [lpfd_pkg::ByteW-1:0]  payload_byte_o,
  input logic                        has_byte_o,
  input logic                        frame_last_o
);

  // A stalled result item holds its valid and its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(conn_id_o) &&
      $stable(ctrl_field_o) && $stable(payload_byte_o) &&
      $stable(has_byte_o) && $stable(frame_last_o))
    else $error("result item changed while stalled");

  // An empty-frame marker always closes its frame and carries a zero byte.
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> frame_last_o && payload_byte_o == '0)
    else $error("empty-frame marker malformed");

  // The input side backs up only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // A result rising in an empty output came via input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input item");

endmodule

bind length_prefixed_frame_deframer_top lpfd_checker u_lpfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .conn_id_o      (conn_id_o),
  .ctrl_field_o   (ctrl_field_o),
  .payload_byte_o (payload_byte_o),
  .has_byte_o     (has_byte_o),
  .frame_last_o   (frame_last_o)
);
